// ===== hw/rtl/stkq_pkg.sv =====
// Shared types and codes for the time-ordered sequence queue.
`default_nettype none

package stkq_pkg;

   // Operation codes carried in the request beat
   typedef enum logic [2:0] {
      OP_ADD      = 3'd0,
      OP_REMOVE   = 3'd1,
      OP_LOOKUP   = 3'd2,
      OP_SMALLEST = 3'd3,
      OP_CLEAR    = 3'd4
   } op_type;

   // Status codes returned in the response beat
   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_MISSING = 2'd2
   } status_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   // Request beat
   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] seq_nr;
      logic [31:0] recv_time;
      logic [31:0] payload_tag;
   } req_type;

   // Response beat
   typedef struct packed {
      logic [1:0]  status;
      logic        found;
      logic [31:0] out_seq;
      logic [31:0] out_time;
      logic [31:0] out_payload;
      logic [3:0]  position;
      logic [4:0]  occupancy;
      logic        is_full;
   } rsp_type;

   // One stored packet record
   typedef struct packed {
      logic [31:0] seq_nr;
      logic [31:0] recv_time;
      logic [31:0] payload_tag;
   } entry_type;

   // Command broadcast from the controller to every cell
   typedef struct packed {
      logic      shift;
      entry_type bus;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/stkq_cell.sv =====
// One storage cell of the queue chain: hold, take the right neighbour, or load the bus.
`default_nettype none

module stkq_cell (
   input  wire                    clock,
   input  stkq_pkg::cell_cmd_type cmd,
   input  wire                    load,
   input  stkq_pkg::entry_type    right,
   output stkq_pkg::entry_type    entry
);
   import stkq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // Pick the next record: a targeted load wins over the chain shift
   always_comb begin
      priority if (load) begin
         entry_in = cmd.bus;
      end else if (cmd.shift) begin
         entry_in = right;
      end else begin
         entry_in = entry_ff;
      end
   end

   // Payload register, no reset needed
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/stkq_ctrl.sv =====
// Sequencer that walks the cell chain by rotation and forms each response beat.
`default_nettype none

module stkq_ctrl #(
   parameter int CAPACITY = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  stkq_pkg::req_type      req_payload,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output stkq_pkg::rsp_type      rsp_payload,
   input  stkq_pkg::entry_type    head,
   output stkq_pkg::cell_cmd_type cmd,
   output logic [CAPACITY-1:0]    load_vec
);
   import stkq_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type        state_ff,  state_in;
   logic [2:0]       op_ff,     op_in;
   entry_type        key_ff,    key_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [CNT_W-1:0] left_ff,   left_in;
   logic [CNT_W-1:0] pos_ff,    pos_in;
   logic             hit_ff,    hit_in;
   entry_type        hit_ent_ff, hit_ent_in;
   logic [CNT_W-1:0] hit_pos_ff, hit_pos_in;
   logic             placed_ff, placed_in;
   logic             drop_ff,   drop_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff,    rsp_in;

   logic [IDX_W-1:0] tail_idx;
   logic [IDX_W-1:0] free_idx;
   logic             rotate;
   logic             insert;
   status_type       status;

   // Tail slot of the live run and first free slot behind it
   assign tail_idx = IDX_W'(count_ff - CNT_W'(1));
   assign free_idx = IDX_W'(count_ff);

   // Next state, walk steps and response forming
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      pos_in       = pos_ff;
      hit_in       = hit_ff;
      hit_ent_in   = hit_ent_ff;
      hit_pos_in   = hit_pos_ff;
      placed_in    = placed_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      rotate       = 1'b0;
      insert       = 1'b0;
      cmd.shift    = 1'b0;
      cmd.bus      = head;
      load_vec     = '0;
      status       = STATUS_DONE;

      // Retire a delivered response beat
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in      = req_payload.operation;
               key_in     = '{seq_nr:      req_payload.seq_nr,
                              recv_time:   req_payload.recv_time,
                              payload_tag: req_payload.payload_tag};
               left_in    = count_ff;
               pos_in     = '0;
               hit_in     = 1'b0;
               hit_pos_in = '0;
               placed_in  = 1'b0;
               drop_in    = 1'b0;
               unique case (req_payload.operation)
                  OP_ADD: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        drop_in  = 1'b1;
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_WALK;
                     end
                  end
                  OP_REMOVE, OP_LOOKUP, OP_SMALLEST: begin
                     state_in = ST_WALK;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_WALK: begin
            if (left_ff != '0) begin
               // Visit the head record, which is the original entry at pos_ff
               unique case (op_ff)
                  OP_ADD: begin
                     if (!placed_ff && (head.recv_time > key_ff.recv_time)) begin
                        insert = 1'b1;
                     end else begin
                        rotate = 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (!hit_ff && (head.seq_nr == key_ff.seq_nr)) begin
                        // Capture and drop the head; the rest closes up
                        hit_in     = 1'b1;
                        hit_ent_in = head;
                        hit_pos_in = pos_ff;
                        cmd.shift  = 1'b1;
                        count_in   = count_ff - CNT_W'(1);
                        left_in    = left_ff - CNT_W'(1);
                        pos_in     = pos_ff + CNT_W'(1);
                     end else begin
                        rotate = 1'b1;
                     end
                  end
                  OP_LOOKUP: begin
                     if (!hit_ff && (head.seq_nr == key_ff.seq_nr)) begin
                        hit_in     = 1'b1;
                        hit_ent_in = head;
                        hit_pos_in = pos_ff;
                     end
                     rotate = 1'b1;
                  end
                  OP_SMALLEST: begin
                     if (!hit_ff || (head.seq_nr < hit_ent_ff.seq_nr)) begin
                        hit_in     = 1'b1;
                        hit_ent_in = head;
                        hit_pos_in = pos_ff;
                     end
                     rotate = 1'b1;
                  end
                  default: begin
                     rotate = 1'b1;
                  end
               endcase
            end else begin
               // Walk done: append the new record if nothing later took it
               if ((op_ff == OP_ADD) && !placed_ff) begin
                  insert = 1'b1;
               end
               state_in = ST_FINISH;
            end

            // Rotate: head moves to the tail, the chain advances
            if (rotate) begin
               cmd.shift          = 1'b1;
               load_vec[tail_idx] = 1'b1;
               left_in            = left_ff - CNT_W'(1);
               pos_in             = pos_ff + CNT_W'(1);
            end

            // Insert: write the new record behind the tail, hold the chain
            if (insert) begin
               cmd.bus            = key_ff;
               load_vec[free_idx] = 1'b1;
               count_in           = count_ff + CNT_W'(1);
               placed_in          = 1'b1;
            end
         end

         ST_FINISH: begin
            unique case (op_ff)
               OP_ADD: begin
                  status = drop_ff ? STATUS_FULL : STATUS_DONE;
               end
               OP_REMOVE, OP_LOOKUP, OP_SMALLEST: begin
                  status = hit_ff ? STATUS_DONE : STATUS_MISSING;
               end
               default: begin
                  status = STATUS_DONE;
               end
            endcase
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status      = status;
               rsp_in.found       = hit_ff;
               rsp_in.out_seq     = hit_ff ? hit_ent_ff.seq_nr : '0;
               rsp_in.out_time    = hit_ff ? hit_ent_ff.recv_time : '0;
               rsp_in.out_payload = hit_ff ? hit_ent_ff.payload_tag : '0;
               rsp_in.position    = hit_ff ? 4'(hit_pos_ff) : '0;
               rsp_in.occupancy   = 5'(count_ff);
               rsp_in.is_full     = (count_ff == CNT_W'(CAPACITY));
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and response registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      left_ff    <= left_in;
      pos_ff     <= pos_in;
      hit_ff     <= hit_in;
      hit_ent_ff <= hit_ent_in;
      hit_pos_ff <= hit_pos_in;
      placed_ff  <= placed_in;
      drop_ff    <= drop_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/seq_keyed_time_ordered_queue.sv =====
// Top level of the time-ordered sequence queue: cell chain plus sequencer.
//
//   channel | direction | handshake           | beat
//   req_    | in        | req_valid/req_ready | stkq_pkg::req_type
//   rsp_    | out       | rsp_valid/rsp_ready | stkq_pkg::rsp_type
//
// One request at a time. An add, remove, lookup or smallest request walks every
// stored record; clear, unused codes and an add to a full table skip the walk.
// The walk rotates the cell chain, one record per cycle past the head cell,
// except in the step where an add writes its new record. A pending response
// beat holds while rsp_ready is low, and a finished request waits until that
// beat has gone; the next request is taken as soon as the sequencer is idle again.
// Reset empties the table at once; the cell contents are not cleared.
`default_nettype none

module seq_keyed_time_ordered_queue #(
   parameter int CAPACITY = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  stkq_pkg::req_type  req_payload,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output stkq_pkg::rsp_type  rsp_payload
);
   import stkq_pkg::*;

   cell_cmd_type        cmd;
   logic [CAPACITY-1:0] load_vec;
   entry_type           cell_q [CAPACITY];

   // Sequencer
   stkq_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .head        (cell_q[0]),
      .cmd         (cmd),
      .load_vec    (load_vec)
   );

   // Chain of cells, each fed by its right neighbour; the last cell feeds itself
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == CAPACITY - 1) begin : g_last
         stkq_cell u_cell (
            .clock (clock),
            .cmd   (cmd),
            .load  (load_vec[i]),
            .right (cell_q[i]),
            .entry (cell_q[i])
         );
      end else begin : g_mid
         stkq_cell u_cell (
            .clock (clock),
            .cmd   (cmd),
            .load  (load_vec[i]),
            .right (cell_q[i+1]),
            .entry (cell_q[i])
         );
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/stkq_checker.sv =====
// Port-level checks for the time-ordered sequence queue, bound to the top level.
`default_nettype none

module stkq_checker #(
   parameter int CAPACITY = 16
) (
   input wire               clock,
   input wire               reset,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input stkq_pkg::rsp_type rsp_payload
);
   import stkq_pkg::*;

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response beat changed while stalled");

   // No response beat straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response beat present after reset");

   // A found entry always comes with a done status
   a_found_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.found |-> rsp_payload.status == STATUS_DONE)
      else $error("found set with a failing status");

   // Without a hit every entry field reads zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.found |->
         rsp_payload.out_seq == '0 && rsp_payload.out_time == '0 &&
         rsp_payload.out_payload == '0 && rsp_payload.position == '0)
      else $error("entry fields set without a hit");

   // A dropped add reports a full table
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STATUS_FULL |->
         rsp_payload.is_full && rsp_payload.occupancy == 5'(CAPACITY))
      else $error("add dropped while table not full");

endmodule

bind seq_keyed_time_ordered_queue stkq_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

`default_nettype wire

// ===== verif/tb_seq_keyed_time_ordered_queue.sv =====
// Self-checking testbench for the time-ordered sequence queue, with a table tracker.

module tb_seq_keyed_time_ordered_queue;
   import stkq_pkg::*;

   localparam int CAPACITY = 16;
   localparam int RANDOM_ITEMS = 1300;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int TAIL_CYCLES = 2 * CAPACITY + 8;
   localparam int MAX_REPORTS = 40;
   // Operation codes the block has no use for
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST = 3'd7;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   int      cycle_count = 0;
   int      add_weight = 45;
   bit      sender_burst = 1'b0;

   // Mirror of the packet table; predicts each response beat and checks the real ones
   class deferred_table;
      logic [31:0] seqs[CAPACITY];
      logic [31:0] stamps[CAPACITY];
      logic [31:0] tags[CAPACITY];
      int          count = 0;
      rsp_type     awaited_rsp[$];
      int          mismatch_count = 0;

      function int pending();
         return awaited_rsp.size();
      endfunction

      task report(string msg);
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %0s", cycle_count, msg);
      endtask

      // Apply one operation to the mirror and return the beat it must produce
      function rsp_type apply_op(req_type r);
         rsp_type e;
         int      k;
         int      i;
         e = '0;
         case (r.operation)
            OP_ADD: begin
               if (count >= CAPACITY) begin
                  e.status = STATUS_FULL;
               end else begin
                  // new entry goes behind every equal or earlier timestamp
                  k = 0;
                  while (k < count && stamps[k] <= r.recv_time) k++;
                  for (i = count; i > k; i--) begin
                     seqs[i] = seqs[i-1];
                     stamps[i] = stamps[i-1];
                     tags[i] = tags[i-1];
                  end
                  seqs[k] = r.seq_nr;
                  stamps[k] = r.recv_time;
                  tags[k] = r.payload_tag;
                  count++;
               end
            end
            OP_REMOVE, OP_LOOKUP: begin
               k = 0;
               while (k < count && seqs[k] != r.seq_nr) k++;
               if (k >= count) begin
                  e.status = STATUS_MISSING;
               end else begin
                  e.found = 1'b1;
                  e.out_seq = seqs[k];
                  e.out_time = stamps[k];
                  e.out_payload = tags[k];
                  e.position = 4'(k);
                  if (r.operation == OP_REMOVE) begin
                     // close up the entries behind the removed one
                     for (i = k; i + 1 < count; i++) begin
                        seqs[i] = seqs[i+1];
                        stamps[i] = stamps[i+1];
                        tags[i] = tags[i+1];
                     end
                     count--;
                  end
               end
            end
            OP_SMALLEST: begin
               if (count == 0) begin
                  e.status = STATUS_MISSING;
               end else begin
                  k = 0;
                  for (i = 1; i < count; i++)
                     if (seqs[i] < seqs[k]) k = i;
                  e.found = 1'b1;
                  e.out_seq = seqs[k];
                  e.out_time = stamps[k];
                  e.out_payload = tags[k];
                  e.position = 4'(k);
               end
            end
            OP_CLEAR: count = 0;
            default: ;
         endcase
         e.occupancy = 5'(count);
         e.is_full = (count == CAPACITY);
         return e;
      endfunction

      function void note_request(req_type r);
         awaited_rsp.push_back(apply_op(r));
      endfunction

      task check_field(string what, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("%0s got %h want %h", what, got, want));
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (awaited_rsp.size() == 0) begin
            report($sformatf("response beat with nothing awaited: %h", got));
         end else begin
            want = awaited_rsp.pop_front();
            check_field("status", 32'(got.status), 32'(want.status));
            check_field("found", 32'(got.found), 32'(want.found));
            check_field("out_seq", got.out_seq, want.out_seq);
            check_field("out_time", got.out_time, want.out_time);
            check_field("out_payload", got.out_payload, want.out_payload);
            check_field("position", 32'(got.position), 32'(want.position));
            check_field("occupancy", 32'(got.occupancy), 32'(want.occupancy));
            check_field("is_full", 32'(got.is_full), 32'(want.is_full));
         end
      endtask
   endclass

   deferred_table table_mirror = new();

   seq_keyed_time_ordered_queue #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   // Clock generation
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watch both channels: check a response beat before noting a new request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) table_mirror.check_response(rsp_payload);
         if (req_valid && req_ready) table_mirror.note_request(req_payload);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL seq_keyed_time_ordered_queue");
         $finish;
      end
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Response side: stretches of ready with random stalls between them
   initial begin
      int high_len;
      int gap;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         high_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 8);
         repeat (high_len) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   function automatic req_type make_req(logic [2:0] op, logic [31:0] seq,
                                        logic [31:0] stamp, logic [31:0] tag);
      req_type r;
      r.operation = op;
      r.seq_nr = seq;
      r.recv_time = stamp;
      r.payload_tag = tag;
      return r;
   endfunction

   // Hold valid with the beat until it is taken; valid stays high on return
   task automatic send_request(input req_type r);
      int gap;
      gap = sender_burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and wait for every awaited response beat
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (table_mirror.pending() != 0) @(posedge clock);
   endtask

   // Small pool for collisions, the top of the range, and anything at all
   function automatic logic [31:0] pick_seq();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(0, 23);
      if (r < 70) return ALL_ONES - $urandom_range(0, 7);
      return $urandom();
   endfunction

   // Narrow range for ties, the extremes, and anything at all
   function automatic logic [31:0] pick_stamp();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(0, 31);
      if (r < 70) return ALL_ONES - $urandom_range(0, 3);
      if (r < 75) return '0;
      return $urandom();
   endfunction

   // Mostly hit a stored sequence number so removes and lookups succeed
   function automatic logic [31:0] pick_known_seq();
      if (table_mirror.count > 0 && $urandom_range(0, 99) < 65)
         return table_mirror.seqs[$urandom_range(0, table_mirror.count - 1)];
      return pick_seq();
   endfunction

   function automatic req_type random_req();
      req_type r;
      int      pick;
      r = make_req(OP_ADD, pick_seq(), pick_stamp(), $urandom());
      if ($urandom_range(0, 99) >= add_weight) begin
         pick = $urandom_range(0, 99);
         r.seq_nr = pick_known_seq();
         if (pick < 45) r.operation = OP_REMOVE;
         else if (pick < 75) r.operation = OP_LOOKUP;
         else if (pick < 92) r.operation = OP_SMALLEST;
         else if (pick < 96) r.operation = OP_CLEAR;
         else r.operation = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      end
      return r;
   endfunction

   // Main sequence
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, extremes, ties, duplicates, full table, clear
      send_request(make_req(OP_LOOKUP, '0, '0, '0));
      send_request(make_req(OP_SMALLEST, ALL_ONES, ALL_ONES, ALL_ONES));
      send_request(make_req(OP_REMOVE, ALL_ONES, '0, '0));
      send_request(make_req(OP_ADD, ALL_ONES, ALL_ONES, ALL_ONES));
      send_request(make_req(OP_ADD, '0, '0, '0));
      send_request(make_req(OP_ADD, 32'd5, ALL_ONES, 32'hA5A5_A5A5));
      send_request(make_req(OP_ADD, 32'd5, '0, 32'h5A5A_5A5A));
      send_request(make_req(OP_LOOKUP, 32'd5, '0, '0));
      send_request(make_req(OP_SMALLEST, '0, '0, '0));
      send_request(make_req(OP_REMOVE, 32'd5, '0, '0));
      send_request(make_req(OP_SPARE_LAST, ALL_ONES, ALL_ONES, ALL_ONES));
      for (int i = 0; i < CAPACITY - 3; i++)
         send_request(make_req(OP_ADD, 32'h8000_0100 + i, 32'(i % 4) * 32'h4000_0000,
                               32'h0F0F_0000 + i));
      send_request(make_req(OP_ADD, 32'd1, 32'd1, 32'd1));
      send_request(make_req(OP_REMOVE, ALL_ONES, '0, '0));
      send_request(make_req(OP_CLEAR, '0, '0, '0));
      hold_until_drained();

      // Random: phases that lean towards filling or emptying the table
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            case ($urandom_range(0, 2))
               0: add_weight = 20;
               1: add_weight = 45;
               default: add_weight = 70;
            endcase
            sender_burst = ($urandom_range(0, 4) == 0);
         end
         if (n > 0 && n % 325 == 0) hold_until_drained();
         send_request(random_req());
      end

      // Let the last responses come, then a few quiet cycles
      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (table_mirror.mismatch_count == 0 && table_mirror.pending() == 0) begin
         $display("PASS seq_keyed_time_ordered_queue");
      end else begin
         $display("FAIL seq_keyed_time_ordered_queue");
      end
      $finish;
   end

endmodule
